// File: rtl/core/bgjc_pkg.sv
// shared types, gains and helpers for the biped gait joint controller
`default_nettype none
package bgjc_pkg;

  localparam int AW  = 16;
  localparam int VW  = 24;
  localparam int TW  = 32;
  localparam int DW  = 32;
  localparam int IXW = 4;
  localparam int PW  = 42;
  localparam int FB  = 16;
  localparam int RW  = PW - FB;

  localparam logic [IXW-1:0] REG_ANKLE_TARGET     = 4'd0;
  localparam logic [IXW-1:0] REG_SHOULDER_TARGET  = 4'd1;
  localparam logic [IXW-1:0] REG_KNEE_TARGET      = 4'd2;
  localparam logic [IXW-1:0] REG_INTER_HIP_TARGET = 4'd3;
  localparam logic [IXW-1:0] REG_TORSO_TARGET     = 4'd4;
  localparam logic [IXW-1:0] REG_EARLY_SWING      = 4'd5;
  localparam logic [IXW-1:0] REG_VOLT_MIN         = 4'd6;
  localparam logic [IXW-1:0] REG_VOLT_MAX         = 4'd7;

  localparam logic signed [PW-1:0] GAIN_ANKLE        = 42'sd2780315;
  localparam logic signed [PW-1:0] GAIN_P5           = 42'sd1390158;
  localparam logic signed [PW-1:0] GAIN_KNEE_LATE    = 42'sd4259840;
  localparam logic signed [PW-1:0] GAIN_SWING_HIP    = 42'sd1112126;
  localparam logic signed [PW-1:0] GAIN_ST_HIP_INTER = 42'sd222425;
  localparam logic signed [PW-1:0] GAIN_ST_HIP_TORSO = 42'sd3892441;
  localparam logic signed [PW-1:0] ROUND_HALF        = 42'sd32768;
  localparam logic signed [RW-1:0] EARLY_KNEE_VOLTS  = -26'sd57344;
  localparam logic signed [VW-1:0] VOLT_MIN_RST      = -24'sd43909;
  localparam logic signed [VW-1:0] VOLT_MAX_RST      = 24'sd43909;
  localparam logic signed [RW-1:0] OUT_MAX           = 26'sd8388607;
  localparam logic signed [RW-1:0] OUT_MIN           = -26'sd8388608;

  typedef struct packed {
    logic signed [AW-1:0] ankle_target;
    logic signed [AW-1:0] shoulder_target;
    logic signed [AW-1:0] knee_target;
    logic signed [AW-1:0] inter_hip_target;
    logic signed [AW-1:0] torso_target;
    logic        [TW-1:0] early_swing_ticks;
    logic signed [VW-1:0] volt_min;
    logic signed [VW-1:0] volt_max;
  } cfg_t;

  typedef struct packed {
    logic                 early;
    logic signed [AW:0]   e_shoulder;
    logic signed [AW+1:0] e_hip;
    logic signed [AW:0]   e_torso;
    logic signed [AW:0]   e_knee_st;
    logic signed [AW:0]   e_knee_sw;
    logic signed [AW:0]   e_ank_st;
    logic signed [AW:0]   e_ank_sw;
  } item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } qctl_t;

  function automatic logic signed [RW-1:0] round16(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = p + ROUND_HALF;
    return $signed(t[PW-1:FB]);
  endfunction

  function automatic logic signed [VW-1:0] sat24(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] s;
    s = v;
    if (v > OUT_MAX) s = OUT_MAX;
    if (v < OUT_MIN) s = OUT_MIN;
    return s[VW-1:0];
  endfunction

  function automatic logic signed [VW-1:0] clamp_lim(input logic signed [RW-1:0] v,
                                                     input logic signed [VW-1:0] lo,
                                                     input logic signed [VW-1:0] hi);
    logic signed [RW-1:0] s;
    s = v;
    if (s > RW'(hi)) s = RW'(hi);
    if (s < RW'(lo)) s = RW'(lo);
    return s[VW-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/biped_gait_joint_controller.sv
// top level of the biped gait joint controller: config registers, front, queue, back
// Usage:
//   in_*  : one sensor item per handshake (in_valid high, in_stall low at a clock edge).
//   out_* : seven joint voltages per item (out_valid high, out_stall low at a clock edge).
//   cfg_* : register writes by index (0..7), cfg_ready is always high; write only
//           while no item is in flight.
// Path: an accepted item is written into the queue, then into the multiply stage,
//   then into the round/clamp output register, where out_valid shows it.
// Throughput: one item per cycle while out_stall is low, set by the single
//   multiply stage and the two-entry queue that feeds it.
// Stall: a stalled output holds its value; the back end freezes, the queue fills,
//   and in_stall rises once both queue entries are taken.
// Reset (rst_n low, synchronous): queue and stages empty, swing timer and
//   contact history cleared, registers to their defaults (limits +-43909).
`default_nettype none
module biped_gait_joint_controller (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [3:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_start_flag,
  input  wire logic [15:0]        in_time_step,
  input  wire logic signed [15:0] in_torso_angle,
  input  wire logic signed [15:0] in_shoulder_angle,
  input  wire logic signed [15:0] in_hip_swing_angle,
  input  wire logic signed [15:0] in_hip_stance_angle,
  input  wire logic signed [15:0] in_knee_swing_angle,
  input  wire logic signed [15:0] in_knee_stance_angle,
  input  wire logic signed [15:0] in_ankle_swing_angle,
  input  wire logic signed [15:0] in_ankle_stance_angle,
  input  wire logic               in_toe_swing_contact,
  input  wire logic               in_heel_swing_contact,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [23:0]      out_shoulder_volts,
  output logic signed [23:0]      out_stance_hip_volts,
  output logic signed [23:0]      out_swing_hip_volts,
  output logic signed [23:0]      out_stance_knee_volts,
  output logic signed [23:0]      out_swing_knee_volts,
  output logic signed [23:0]      out_stance_ankle_volts,
  output logic signed [23:0]      out_swing_ankle_volts
);
  import bgjc_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  item_t f_item, q_item;
  qctl_t qctl;
  logic  push, pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_ANKLE_TARGET:     cfg_nxt.ankle_target     = cfg_data[AW-1:0];
        REG_SHOULDER_TARGET:  cfg_nxt.shoulder_target  = cfg_data[AW-1:0];
        REG_KNEE_TARGET:      cfg_nxt.knee_target      = cfg_data[AW-1:0];
        REG_INTER_HIP_TARGET: cfg_nxt.inter_hip_target = cfg_data[AW-1:0];
        REG_TORSO_TARGET:     cfg_nxt.torso_target     = cfg_data[AW-1:0];
        REG_EARLY_SWING:      cfg_nxt.early_swing_ticks = cfg_data[TW-1:0];
        REG_VOLT_MIN:         cfg_nxt.volt_min         = cfg_data[VW-1:0];
        REG_VOLT_MAX:         cfg_nxt.volt_max         = cfg_data[VW-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ankle_target      <= '0;
      cfg_r.shoulder_target   <= '0;
      cfg_r.knee_target       <= '0;
      cfg_r.inter_hip_target  <= '0;
      cfg_r.torso_target      <= '0;
      cfg_r.early_swing_ticks <= '0;
      cfg_r.volt_min          <= VOLT_MIN_RST;
      cfg_r.volt_max          <= VOLT_MAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bgjc_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg_r),
    .q_full                (qctl.full),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_start_flag         (in_start_flag),
    .in_time_step          (in_time_step),
    .in_torso_angle        (in_torso_angle),
    .in_shoulder_angle     (in_shoulder_angle),
    .in_hip_swing_angle    (in_hip_swing_angle),
    .in_hip_stance_angle   (in_hip_stance_angle),
    .in_knee_swing_angle   (in_knee_swing_angle),
    .in_knee_stance_angle  (in_knee_stance_angle),
    .in_ankle_swing_angle  (in_ankle_swing_angle),
    .in_ankle_stance_angle (in_ankle_stance_angle),
    .in_toe_swing_contact  (in_toe_swing_contact),
    .in_heel_swing_contact (in_heel_swing_contact),
    .push                  (push),
    .item                  (f_item)
  );

  bgjc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (f_item),
    .pop     (pop),
    .rd_item (q_item),
    .ctl     (qctl)
  );

  bgjc_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg_r),
    .qctl                   (qctl),
    .item                   (q_item),
    .pop                    (pop),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_shoulder_volts     (out_shoulder_volts),
    .out_stance_hip_volts   (out_stance_hip_volts),
    .out_swing_hip_volts    (out_swing_hip_volts),
    .out_stance_knee_volts  (out_stance_knee_volts),
    .out_swing_knee_volts   (out_swing_knee_volts),
    .out_stance_ankle_volts (out_stance_ankle_volts),
    .out_swing_ankle_volts  (out_swing_ankle_volts)
  );

endmodule
`default_nettype wire

// File: rtl/core/bgjc_front.sv
// front end: accepts samples, runs the swing timer, forms the angle errors
`default_nettype none
module bgjc_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire bgjc_pkg::cfg_t               cfg,
  input  wire logic                         q_full,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_start_flag,
  input  wire logic [15:0]                  in_time_step,
  input  wire logic signed [15:0]           in_torso_angle,
  input  wire logic signed [15:0]           in_shoulder_angle,
  input  wire logic signed [15:0]           in_hip_swing_angle,
  input  wire logic signed [15:0]           in_hip_stance_angle,
  input  wire logic signed [15:0]           in_knee_swing_angle,
  input  wire logic signed [15:0]           in_knee_stance_angle,
  input  wire logic signed [15:0]           in_ankle_swing_angle,
  input  wire logic signed [15:0]           in_ankle_stance_angle,
  input  wire logic                         in_toe_swing_contact,
  input  wire logic                         in_heel_swing_contact,
  output logic                              push,
  output bgjc_pkg::item_t                   item
);
  import bgjc_pkg::*;

  logic [TW-1:0] timer_r, timer_nxt;
  logic          prev_touch_r, prev_touch_nxt;
  logic          touch;
  logic signed [AW:0] hip_diff;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign touch    = in_toe_swing_contact || in_heel_swing_contact;

  always_comb begin
    timer_nxt = in_start_flag ? '0 : timer_r + TW'(in_time_step);
    if (touch && !prev_touch_r) timer_nxt = '0;
    prev_touch_nxt = touch;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r      <= '0;
      prev_touch_r <= 1'b0;
    end else if (push) begin
      timer_r      <= timer_nxt;
      prev_touch_r <= prev_touch_nxt;
    end
  end

  assign hip_diff = (AW+1)'(in_hip_swing_angle) - (AW+1)'(in_hip_stance_angle);

  always_comb begin
    item.early      = timer_nxt < cfg.early_swing_ticks;
    item.e_shoulder = (AW+1)'(cfg.shoulder_target) - (AW+1)'(in_shoulder_angle);
    item.e_hip      = (AW+2)'(cfg.inter_hip_target) - (AW+2)'(hip_diff);
    item.e_torso    = (AW+1)'(cfg.torso_target) - (AW+1)'(in_torso_angle);
    item.e_knee_st  = (AW+1)'(cfg.knee_target) - (AW+1)'(in_knee_stance_angle);
    item.e_knee_sw  = (AW+1)'(cfg.knee_target) - (AW+1)'(in_knee_swing_angle);
    item.e_ank_st   = (AW+1)'(cfg.ankle_target) - (AW+1)'(in_ankle_stance_angle);
    item.e_ank_sw   = (AW+1)'(cfg.ankle_target) - (AW+1)'(in_ankle_swing_angle);
  end

endmodule
`default_nettype wire

// File: rtl/core/bgjc_queue.sv
// two-entry queue between front end and back end
`default_nettype none
module bgjc_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire bgjc_pkg::item_t wr_item,
  input  wire logic            pop,
  output bgjc_pkg::item_t      rd_item,
  output bgjc_pkg::qctl_t      ctl
);
  import bgjc_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign ctl.push  = push;
  assign ctl.pop   = pop;
  assign ctl.full  = count_r == 2'd2;
  assign ctl.empty = count_r == 2'd0;
  assign rd_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_item;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.full |-> !push) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.empty |-> !pop) else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 2'd1) else $error("queue count slip");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");

endmodule
`default_nettype wire

// File: rtl/core/bgjc_back.sv
// back end: gain multiply, rounding, saturation and clamping, output register
`default_nettype none
module bgjc_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bgjc_pkg::cfg_t     cfg,
  input  wire bgjc_pkg::qctl_t    qctl,
  input  wire bgjc_pkg::item_t    item,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [23:0]      out_shoulder_volts,
  output logic signed [23:0]      out_stance_hip_volts,
  output logic signed [23:0]      out_swing_hip_volts,
  output logic signed [23:0]      out_stance_knee_volts,
  output logic signed [23:0]      out_swing_knee_volts,
  output logic signed [23:0]      out_stance_ankle_volts,
  output logic signed [23:0]      out_swing_ankle_volts
);
  import bgjc_pkg::*;

  logic advance;
  logic v1_r, v1_nxt;
  logic ov_r, ov_nxt;

  logic                 early_r;
  logic signed [PW-1:0] p_sh_r, p_hi_r, p_to_r, p_kst_r, p_ksw_r, p_ast_r, p_asw_r, p_swh_r;
  logic signed [PW-1:0] p_sh_nxt, p_hi_nxt, p_to_nxt, p_kst_nxt, p_ksw_nxt;
  logic signed [PW-1:0] p_ast_nxt, p_asw_nxt, p_swh_nxt;
  logic signed [PW-1:0] st_hip_sum;
  logic signed [RW-1:0] knee_v;

  logic signed [VW-1:0] sh_r, sth_r, swh_r, stk_r, swk_r, sta_r, swa_r;
  logic signed [VW-1:0] sh_nxt, sth_nxt, swh_nxt, stk_nxt, swk_nxt, sta_nxt, swa_nxt;

  assign advance = !ov_r || !out_stall;
  assign pop     = advance && !qctl.empty;

  always_comb begin
    p_sh_nxt  = GAIN_P5           * PW'(item.e_shoulder);
    p_hi_nxt  = GAIN_ST_HIP_INTER * PW'(item.e_hip);
    p_swh_nxt = GAIN_SWING_HIP    * PW'(item.e_hip);
    p_to_nxt  = GAIN_ST_HIP_TORSO * PW'(item.e_torso);
    p_kst_nxt = GAIN_P5           * PW'(item.e_knee_st);
    p_ksw_nxt = GAIN_KNEE_LATE    * PW'(item.e_knee_sw);
    p_ast_nxt = GAIN_ANKLE        * PW'(item.e_ank_st);
    p_asw_nxt = GAIN_ANKLE        * PW'(item.e_ank_sw);
  end

  always_comb begin
    st_hip_sum = -p_hi_r - p_to_r;
    knee_v     = early_r ? EARLY_KNEE_VOLTS : round16(p_ksw_r);
    sh_nxt     = sat24(round16(p_sh_r));
    sth_nxt    = clamp_lim(round16(st_hip_sum), cfg.volt_min, cfg.volt_max);
    swh_nxt    = clamp_lim(round16(p_swh_r), cfg.volt_min, cfg.volt_max);
    stk_nxt    = sat24(round16(p_kst_r));
    swk_nxt    = clamp_lim(knee_v, cfg.volt_min, cfg.volt_max);
    sta_nxt    = sat24(round16(p_ast_r));
    swa_nxt    = sat24(round16(p_asw_r));
    v1_nxt     = advance ? !qctl.empty : v1_r;
    ov_nxt     = advance ? v1_r : ov_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      early_r <= item.early;
      p_sh_r  <= p_sh_nxt;
      p_hi_r  <= p_hi_nxt;
      p_swh_r <= p_swh_nxt;
      p_to_r  <= p_to_nxt;
      p_kst_r <= p_kst_nxt;
      p_ksw_r <= p_ksw_nxt;
      p_ast_r <= p_ast_nxt;
      p_asw_r <= p_asw_nxt;
    end
    if (advance && v1_r) begin
      sh_r  <= sh_nxt;
      sth_r <= sth_nxt;
      swh_r <= swh_nxt;
      stk_r <= stk_nxt;
      swk_r <= swk_nxt;
      sta_r <= sta_nxt;
      swa_r <= swa_nxt;
    end
  end

  assign out_valid              = ov_r;
  assign out_shoulder_volts     = sh_r;
  assign out_stance_hip_volts   = sth_r;
  assign out_swing_hip_volts    = swh_r;
  assign out_stance_knee_volts  = stk_r;
  assign out_swing_knee_volts   = swk_r;
  assign out_stance_ankle_volts = sta_r;
  assign out_swing_ankle_volts  = swa_r;

  a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> ov_r && v1_r == $past(v1_r)) else $error("stalled stage moved");
  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> v1_r) else $error("popped item lost");
  a_stage_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && advance) |=> ov_r) else $error("stage item not delivered");

endmodule
`default_nettype wire
